// ===== rtl/ihex_pkg.sv =====
// shared types and codes for the intel hex record parser
// no dependencies; imported by ihex_core, the top level and the checker
`timescale 1ns / 1ps

package ihex_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX  = 2'd1;
  localparam logic [1:0] ERR_PAD_BYTE = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  // special characters
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // record types with their own handling
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EOF      = 8'h01;
  localparam logic [7:0] REC_EXT_LIN  = 8'h04;

  // one result beat
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [30:0] block_address;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
    logic        pad_byte;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ===== rtl/intel_hex_record_parser.sv =====
// top level of the intel hex record parser: input register, record core, result register
// depends on ihex_pkg and ihex_core
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------------
//   text     | text_valid / text_ready     | text_char
//   result   | result_valid / result_ready | result_kind, block_address, byte_offset,
//            |                             | data_byte, pad_byte, error_code
//
// one character per cycle sustained while results are taken; a result is offered from the
// result register after its character has passed the input register and the core.
// the record state machine in ihex_core takes one step per character.
// reset clears both valid flags and the record state; no result is pending after it.
// a stalled result holds the core; the input register still takes one more beat.
`timescale 1ns / 1ps

module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_char,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  result_kind,
  output logic [30:0] block_address,
  output logic [7:0]  byte_offset,
  output logic [7:0]  data_byte,
  output logic        pad_byte,
  output logic [1:0]  error_code
);
  import ihex_pkg::*;

  logic      text_q_valid;
  logic [7:0] text_q;
  logic      advance;
  logic      step;
  logic      res_valid;
  result_t   res;
  result_t   result_q;

  // result slot free or emptying this cycle
  assign advance    = !result_valid || result_ready;
  assign step       = text_q_valid && advance;
  assign text_ready = !text_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_q_valid <= 1'b0;
    end else if (text_ready) begin
      text_q_valid <= text_valid;
    end
    if (text_valid && text_ready) begin
      text_q <= text_char;
    end
  end

  ihex_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .ch        (text_q),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && res_valid;
    end
    if (step && res_valid) begin
      result_q <= res;
    end
  end

  assign result_kind   = result_q.result_kind;
  assign block_address = result_q.block_address;
  assign byte_offset   = result_q.byte_offset;
  assign data_byte     = result_q.data_byte;
  assign pad_byte      = result_q.pad_byte;
  assign error_code    = result_q.error_code;

endmodule

// ===== rtl/ihex_core.sv =====
// record state machine of the intel hex parser: one character per step
// depends on ihex_pkg
`timescale 1ns / 1ps

module ihex_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  output logic             res_valid,
  output ihex_pkg::result_t res
);
  import ihex_pkg::*;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_SKIP       = 4'd1,
    PH_COUNT      = 4'd2,
    PH_ADDR_HI    = 4'd3,
    PH_ADDR_LO    = 4'd4,
    PH_TYPE       = 4'd5,
    PH_DATA       = 4'd6,
    PH_EXT_HI     = 4'd7,
    PH_EXT_LO     = 4'd8,
    PH_CHECK      = 4'd9
  } phase_t;

  phase_t      phase, phase_next;
  logic        second_nibble, second_nibble_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  record_length, record_length_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic [15:0] upper_address, upper_address_next;
  logic [31:0] running_address, running_address_next;
  logic [7:0]  record_sum, record_sum_next;
  logic        finished, finished_next;
  logic        failed, failed_next;

  logic        hex_ok;
  logic [3:0]  nib;
  logic [7:0]  full_byte;
  logic [7:0]  sum_add;
  logic        pad_pos;

  // hex digit decode
  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    case (ch) inside
      [8'h30:8'h39]: nib = ch[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: nib = ch[3:0] + 4'd9;
      default:       hex_ok = 1'b0;
    endcase
  end

  assign full_byte = {high_nibble, nib};
  assign sum_add   = record_sum + full_byte;
  assign pad_pos   = (running_address[1:0] == 2'b11);

  // next state and result for the current character
  always_comb begin
    phase_next           = phase;
    second_nibble_next   = second_nibble;
    high_nibble_next     = high_nibble;
    record_length_next   = record_length;
    record_type_next     = record_type;
    bytes_remaining_next = bytes_remaining;
    upper_address_next   = upper_address;
    running_address_next = running_address;
    record_sum_next      = record_sum;
    finished_next        = finished;
    failed_next          = failed;
    res_valid            = 1'b0;
    res                  = '0;

    if (!(failed || finished)) begin
      case (phase)
        PH_LINE_START: begin
          if (ch == CHAR_COLON) begin
            phase_next         = PH_COUNT;
            second_nibble_next = 1'b0;
          end else if (ch != CHAR_NEWLINE) begin
            phase_next = PH_SKIP;
          end
        end
        PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA,
        PH_EXT_HI, PH_EXT_LO, PH_CHECK: begin
          if (!hex_ok) begin
            failed_next    = 1'b1;
            res_valid      = 1'b1;
            res.result_kind = KIND_ERROR;
            res.error_code  = ERR_BAD_HEX;
          end else if (!second_nibble) begin
            high_nibble_next   = nib;
            second_nibble_next = 1'b1;
          end else begin
            second_nibble_next = 1'b0;
            record_sum_next    = sum_add;
            case (phase)
              PH_COUNT: begin
                record_length_next = full_byte;
                phase_next         = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                running_address_next = {16'd0, full_byte, 8'd0};
                phase_next           = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                running_address_next = {running_address[31:8], full_byte};
                phase_next           = PH_TYPE;
              end
              PH_TYPE: begin
                record_type_next = full_byte;
                if (full_byte == REC_DATA) begin
                  running_address_next = {upper_address, running_address[15:0]};
                  bytes_remaining_next = record_length;
                  phase_next = (record_length == 8'd0) ? PH_CHECK : PH_DATA;
                end else if (full_byte == REC_EXT_LIN) begin
                  phase_next = PH_EXT_HI;
                end else begin
                  phase_next = PH_CHECK;
                end
              end
              PH_DATA: begin
                res_valid = 1'b1;
                if (pad_pos && full_byte != 8'd0) begin
                  failed_next     = 1'b1;
                  res.result_kind = KIND_ERROR;
                  res.error_code  = ERR_PAD_BYTE;
                end else begin
                  res.result_kind   = KIND_DATA;
                  res.block_address = {running_address[31:8], 7'd0};
                  res.byte_offset   = running_address[7:0];
                  res.data_byte     = full_byte;
                  res.pad_byte      = pad_pos;
                  running_address_next = running_address + 32'd1;
                  bytes_remaining_next = bytes_remaining - 8'd1;
                  if (bytes_remaining == 8'd1) begin
                    phase_next = PH_CHECK;
                  end
                end
              end
              PH_EXT_HI: begin
                upper_address_next = {full_byte, 8'd0};
                phase_next         = PH_EXT_LO;
              end
              PH_EXT_LO: begin
                upper_address_next = {upper_address[15:8], full_byte};
                phase_next         = PH_CHECK;
              end
              default: begin
                // checksum byte closes the record
                if (sum_add != 8'd0) begin
                  failed_next     = 1'b1;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
                  res.error_code  = ERR_CHECKSUM;
                end else if (record_type == REC_EOF) begin
                  finished_next   = 1'b1;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_EOF;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
            endcase
          end
        end
        default: begin
          // skip to end of line
          if (ch == CHAR_NEWLINE) begin
            phase_next = PH_LINE_START;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LINE_START;
      second_nibble   <= 1'b0;
      high_nibble     <= 4'd0;
      record_length   <= 8'd0;
      record_type     <= 8'd0;
      bytes_remaining <= 8'd0;
      upper_address   <= 16'd0;
      running_address <= 32'd0;
      record_sum      <= 8'd0;
      finished        <= 1'b0;
      failed          <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      second_nibble   <= second_nibble_next;
      high_nibble     <= high_nibble_next;
      record_length   <= record_length_next;
      record_type     <= record_type_next;
      bytes_remaining <= bytes_remaining_next;
      upper_address   <= upper_address_next;
      running_address <= running_address_next;
      record_sum      <= record_sum_next;
      finished        <= finished_next;
      failed          <= failed_next;
    end
  end

endmodule

// ===== rtl/ihex_checker.sv =====
// port-level checks for the intel hex record parser, bound to the top level
// depends on ihex_pkg and intel_hex_record_parser
`timescale 1ns / 1ps

module ihex_checker (
  input logic        clk,
  input logic        rst,
  input logic        text_valid,
  input logic        text_ready,
  input logic [7:0]  text_char,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  result_kind,
  input logic [30:0] block_address,
  input logic [7:0]  byte_offset,
  input logic [7:0]  data_byte,
  input logic        pad_byte,
  input logic [1:0]  error_code
);
  import ihex_pkg::*;

  // a stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_kind)
      && $stable(block_address) && $stable(byte_offset) && $stable(data_byte))
    else $error("result beat changed while stalled");

  // parsing stops after an end-of-file or error beat
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready &&
      (result_kind == KIND_EOF || result_kind == KIND_ERROR) |=> !result_valid)
    else $error("result beat after end of parsing");

  // pad flag follows the offset within the dword
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_DATA |->
      pad_byte == (byte_offset[1:0] == 2'b11) && error_code == ERR_NONE)
    else $error("data beat has wrong pad flag or error code");

  // error beats carry a code and no data fields
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_ERROR |->
      error_code != ERR_NONE && block_address == 31'd0 && data_byte == 8'd0
      && !pad_byte)
    else $error("malformed error beat");

  // nothing is pending right after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);

// ===== test/intel_hex_record_parser_tb.sv =====
// testbench for intel_hex_record_parser: hex text in, data/eof/error beats out
// depends on ihex_pkg and the intel_hex_record_parser rtl; self-checking, no files
`timescale 1ns / 1ps

module intel_hex_record_parser_tb;
  import ihex_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 10;
  localparam int unsigned PRINT_CAP    = 30;
  localparam int          NUM_ROWS     = 16;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  // scan position inside a line
  typedef enum logic [3:0] {
    SCAN_LINE_START, SCAN_SKIP, SCAN_COUNT, SCAN_ADDR_HI, SCAN_ADDR_LO,
    SCAN_TYPE, SCAN_DATA, SCAN_EXT_HI, SCAN_EXT_LO, SCAN_CHECKSUM
  } scan_phase_t;

  // the parser locks after its first error or end record, so a run closes with at most one
  typedef enum int {
    CLOSE_EOF, CLOSE_BAD_HEX, CLOSE_NEWLINE, CLOSE_PAD, CLOSE_CHECKSUM, CLOSE_NONE
  } closing_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_char = 8'h00;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [30:0] block_address;
  logic [7:0]  byte_offset;
  logic [7:0]  data_byte;
  logic        pad_byte;
  logic [1:0]  error_code;

  intel_hex_record_parser DUT (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_ready(text_ready), .text_char(text_char),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_kind(result_kind), .block_address(block_address),
    .byte_offset(byte_offset), .data_byte(data_byte),
    .pad_byte(pad_byte), .error_code(error_code)
  );

  // parser model state
  scan_phase_t scan_phase = SCAN_LINE_START;
  bit          low_nibble_next = 1'b0;
  logic [3:0]  held_nibble = '0;
  logic [7:0]  rec_length = '0;
  logic [7:0]  rec_type = '0;
  logic [7:0]  data_left = '0;
  logic [15:0] upper_half = '0;
  logic [31:0] byte_address = '0;
  logic [7:0]  rec_sum = '0;
  bit          hit_eof = 1'b0;
  bit          hit_error = 1'b0;

  result_t     pending_results[$];
  logic [7:0]  line_chars[$];
  logic [7:0]  body_bytes[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_checked = 0;
  int unsigned data_beats = 0;
  int unsigned chars_sent = 0;
  int unsigned cycle_count = 0;
  bit          steady_line = 1'b0;
  bit          hold_requested = 1'b0;
  bit          use_typed = 1'b0;
  result_t     typed_want = '0;

  // directed lines; expected beat typed in where it is obvious, else predicted
  string   row_text [NUM_ROWS] = '{
    "# comment line, skipped",
    "",
    ":0100000000FF",
    ":01000100FFFF",
    ":02000004aBcD82",
    ":04000800112233008E",
    ":00001000F0",
    " :0100000000FF",
    ":02000002FC1234 trailing text",
    ":000000FF01",
    "\200\377~ high bytes skipped",
    ":02000004FFFFFC",
    ":01FFFC00778D",
    ":04FFFE00AB00CDEF98",
    ":020000040000FA",
    ":0100030000FC"
  };
  bit      row_typed [NUM_ROWS] = '{0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1};
  result_t row_want [NUM_ROWS] = '{
    '0, '0,
    {KIND_DATA, 31'd0, 8'h00, 8'h00, 1'b0, ERR_NONE},
    {KIND_DATA, 31'd0, 8'h01, 8'hFF, 1'b0, ERR_NONE},
    '0, '0, '0, '0, '0, '0, '0, '0,
    {KIND_DATA, 31'h7FFFFF80, 8'hFC, 8'h77, 1'b0, ERR_NONE},
    '0, '0,
    {KIND_DATA, 31'd0, 8'h03, 8'h00, 1'b1, ERR_NONE}
  };

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending",
               cycle_count, pending_results.size());
      $display("** intel_hex_record_parser: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  // predicted beat for one accepted character
  task automatic parse_char(input logic [7:0] c, output bit got, output result_t r);
    int         nib;
    logic [7:0] b;
    got = 1'b0;
    r = '0;
    if (hit_error || hit_eof) return;
    if (scan_phase == SCAN_LINE_START) begin
      if (c == CHAR_COLON) begin
        scan_phase = SCAN_COUNT;
        low_nibble_next = 1'b0;
      end else if (c != CHAR_NEWLINE) begin
        scan_phase = SCAN_SKIP;
      end
      return;
    end
    if (scan_phase == SCAN_SKIP) begin
      if (c == CHAR_NEWLINE) scan_phase = SCAN_LINE_START;
      return;
    end
    nib = hex_digit(c);
    if (nib < 0) begin
      hit_error = 1'b1;
      got = 1'b1;
      r.result_kind = KIND_ERROR;
      r.error_code = ERR_BAD_HEX;
      return;
    end
    if (!low_nibble_next) begin
      held_nibble = nib[3:0];
      low_nibble_next = 1'b1;
      return;
    end
    low_nibble_next = 1'b0;
    b = {held_nibble, nib[3:0]};
    rec_sum = rec_sum + b;
    case (scan_phase)
      SCAN_COUNT: begin
        rec_length = b;
        scan_phase = SCAN_ADDR_HI;
      end
      SCAN_ADDR_HI: begin
        byte_address = {16'h0000, b, 8'h00};
        scan_phase = SCAN_ADDR_LO;
      end
      SCAN_ADDR_LO: begin
        byte_address = byte_address | {24'h0, b};
        scan_phase = SCAN_TYPE;
      end
      SCAN_TYPE: begin
        rec_type = b;
        if (b == REC_DATA) begin
          byte_address = {upper_half, byte_address[15:0]};
          data_left = rec_length;
          scan_phase = (rec_length == 8'h00) ? SCAN_CHECKSUM : SCAN_DATA;
        end else if (b == REC_EXT_LIN) begin
          scan_phase = SCAN_EXT_HI;
        end else begin
          scan_phase = SCAN_CHECKSUM;
        end
      end
      SCAN_DATA: begin
        got = 1'b1;
        if (byte_address[1:0] == 2'b11 && b != 8'h00) begin
          hit_error = 1'b1;
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_PAD_BYTE;
        end else begin
          r.result_kind = KIND_DATA;
          r.block_address = {byte_address[31:8], 7'd0};
          r.byte_offset = byte_address[7:0];
          r.data_byte = b;
          r.pad_byte = (byte_address[1:0] == 2'b11);
          r.error_code = ERR_NONE;
          byte_address = byte_address + 32'd1;
          data_left = data_left - 8'd1;
          if (data_left == 8'h00) scan_phase = SCAN_CHECKSUM;
        end
      end
      SCAN_EXT_HI: begin
        upper_half = {b, 8'h00};
        scan_phase = SCAN_EXT_LO;
      end
      SCAN_EXT_LO: begin
        upper_half = upper_half | {8'h00, b};
        scan_phase = SCAN_CHECKSUM;
      end
      default: begin
        if (rec_sum != 8'h00) begin
          hit_error = 1'b1;
          got = 1'b1;
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_CHECKSUM;
        end else if (rec_type == REC_EOF) begin
          hit_eof = 1'b1;
          got = 1'b1;
          r.result_kind = KIND_EOF;
        end else begin
          scan_phase = SCAN_SKIP;
        end
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one character beat, predicted at the edge where it is taken
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    bit          got;
    result_t     r;
    gap = steady_line ? 0 : pick_gap();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_char <= c;
    do @(posedge clk); while (!text_ready);
    parse_char(c, got, r);
    if (got) pending_results.push_back(use_typed ? typed_want : r);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_chars[k]) send_char(line_chars[k]);
    send_char(CHAR_NEWLINE);
    line_chars.delete();
  endtask

  // sender pause until every pending beat is out
  task automatic drain_results();
    text_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'h0, n};
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    line_chars.push_back(hex_char(b[7:4]));
    line_chars.push_back(hex_char(b[3:0]));
  endtask

  // record from body_bytes; skew spoils the checksum when nonzero
  task automatic build_record(input logic [7:0] count, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic [7:0] skew);
    logic [7:0] sum;
    sum = count + addr[15:8] + addr[7:0] + rtype;
    foreach (body_bytes[i]) sum = sum + body_bytes[i];
    line_chars.push_back(CHAR_COLON);
    push_byte(count);
    push_byte(addr[15:8]);
    push_byte(addr[7:0]);
    push_byte(rtype);
    foreach (body_bytes[i]) push_byte(body_bytes[i]);
    push_byte(8'h00 - sum + skew);
  endtask

  task automatic make_data_record(input int unsigned len, input bit pad_fault,
                                  input logic [7:0] skew);
    logic [15:0] addr;
    logic [7:0]  b;
    logic [1:0]  pos;
    addr = 16'($urandom_range(0, 16'hFFFF));
    body_bytes.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      pos = addr[1:0] + i[1:0];
      if (pos == 2'b11) b = 8'h00;
      body_bytes.push_back(b);
    end
    // first pad position in the record gets a nonzero value
    if (pad_fault) body_bytes[2'b11 - addr[1:0]] = 8'($urandom_range(1, 255));
    build_record(len[7:0], addr, REC_DATA, skew);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 16);
    if (r < 98) return $urandom_range(17, 64);
    if (r == 98) return $urandom_range(65, 254);
    return 255;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, kind %0d",
                                  result_kind));
      end else begin
        want = pending_results.pop_front();
        if (want.result_kind == KIND_DATA) data_beats++;
        compare_field("result_kind", 32'(result_kind), 32'(want.result_kind));
        compare_field("block_address", 32'(block_address), 32'(want.block_address));
        compare_field("byte_offset", 32'(byte_offset), 32'(want.byte_offset));
        compare_field("data_byte", 32'(data_byte), 32'(want.data_byte));
        compare_field("pad_byte", 32'(pad_byte), 32'(want.pad_byte));
        compare_field("error_code", 32'(error_code), 32'(want.error_code));
      end
    end
  end

  // result side: ready runs, short and long stalls, one long hold-off on request
  initial begin
    int unsigned run_len;
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requested) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_requested = 1'b0;
      end else begin
        result_ready <= 1'b1;
        run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 12);
        repeat (run_len) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          result_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned pick;
    int unsigned p;
    logic [7:0]  c;
    logic [7:0]  rtype;
    logic [15:0] upper;
    bit          hold_done;
    bit          drain_done;
    bit          force_data;
    closing_t    close_case;
    string       close_note;

    hold_done = 1'b0;
    drain_done = 1'b0;
    force_data = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines
    for (int i = 0; i < NUM_ROWS; i++) begin
      use_typed = row_typed[i];
      typed_want = row_want[i];
      steady_line = 1'($urandom_range(0, 1));
      for (int k = 0; k < row_text[i].len(); k++) line_chars.push_back(row_text[i][k]);
      send_line();
    end
    use_typed = 1'b0;
    drain_results();

    // random lines, mostly well-formed records
    while (chars_sent < ITEM_TARGET) begin
      steady_line = ($urandom_range(0, 3) == 0);
      if (!hold_done && chars_sent > 500) begin
        hold_requested = 1'b1;
        hold_done = 1'b1;
        force_data = 1'b1;
      end
      if (!drain_done && chars_sent > 900) begin
        drain_results();
        drain_done = 1'b1;
      end
      pick = force_data ? 0 : $urandom_range(0, 99);
      if (pick < 60) begin
        make_data_record(force_data ? $urandom_range(8, 16) : pick_length(), 1'b0, 8'h00);
        force_data = 1'b0;
      end else if (pick < 75) begin
        p = $urandom_range(0, 3);
        upper = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF));
        body_bytes = '{upper[15:8], upper[7:0]};
        build_record(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h02,
                     16'($urandom_range(0, 16'hFFFF)), REC_EXT_LIN, 8'h00);
      end else if (pick < 85) begin
        do rtype = 8'($urandom_range(2, 255)); while (rtype == REC_EXT_LIN);
        body_bytes.delete();
        build_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                     rtype, 8'h00);
      end else if (pick < 95) begin
        // noise line
        p = $urandom_range(0, 20);
        for (int i = 0; i < p; i++) begin
          do c = junk_char(); while (i == 0 && c == CHAR_COLON);
          line_chars.push_back(c);
        end
      end else begin
        // record hidden behind a leading character
        do c = junk_char(); while (c == CHAR_COLON);
        line_chars.push_back(c);
        make_data_record($urandom_range(1, 8), 1'b0, 8'h00);
      end
      // text after the checksum is ignored
      if (pick < 95 && $urandom_range(0, 9) < 3) begin
        p = $urandom_range(1, 5);
        repeat (p) line_chars.push_back(junk_char());
      end
      send_line();
    end

    // closing line
    close_case = closing_t'($urandom_range(0, 5));
    steady_line = 1'b0;
    case (close_case)
      CLOSE_EOF: begin
        close_note = "end-of-file record";
        body_bytes.delete();
        build_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                     REC_EOF, 8'h00);
      end
      CLOSE_BAD_HEX: begin
        close_note = "invalid hex digit";
        make_data_record($urandom_range(1, 8), 1'b0, 8'h00);
        p = $urandom_range(1, line_chars.size() - 1);
        do c = junk_char(); while (hex_digit(c) >= 0);
        line_chars[p] = c;
      end
      CLOSE_NEWLINE: begin
        close_note = "newline inside a record";
        make_data_record($urandom_range(1, 8), 1'b0, 8'h00);
        p = $urandom_range(1, line_chars.size() - 1);
        while (line_chars.size() > p) void'(line_chars.pop_back());
        line_chars.push_back(CHAR_NEWLINE);
      end
      CLOSE_PAD: begin
        close_note = "nonzero pad byte";
        make_data_record($urandom_range(4, 16), 1'b1, 8'h00);
      end
      CLOSE_CHECKSUM: begin
        close_note = "checksum failure";
        make_data_record($urandom_range(0, 16), 1'b0, 8'($urandom_range(1, 255)));
      end
      default: close_note = "text ended without an end record";
    endcase
    if (close_case != CLOSE_NONE) begin
      send_line();
      // parser is locked now; nothing more may come out
      make_data_record(4, 1'b0, 8'h00);
      send_line();
      p = $urandom_range(1, 12);
      repeat (p) line_chars.push_back(junk_char());
      send_line();
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d characters and %0d result beats (%0d data bytes) in %0d cycles",
             chars_sent, beats_checked, data_beats, cycle_count);
    $display("stream closed with: %s", close_note);
    if (mismatch_count == 0) begin
      $display("** intel_hex_record_parser: PASSED **");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("** intel_hex_record_parser: FAILED **");
    end
    $finish;
  end

endmodule
